[rtl/jrpr_pkg.sv]
package jrpr_pkg;

    localparam int LedCountDefault = 32;
    localparam int AdcMaxDefault   = 4095;

    localparam int CordicSteps = 16;

    typedef enum logic [2:0] {
        REG_STICK_CENTER   = 3'd0,
        REG_DEAD_ZONE      = 3'd1,
        REG_WIDTH_LEAST    = 3'd2,
        REG_WIDTH_MOST     = 3'd3,
        REG_POINTER_RGB    = 3'd4,
        REG_BACKDROP_RGB   = 3'd5,
        REG_POINTER_LEVEL  = 3'd6,
        REG_BACKDROP_LEVEL = 3'd7
    } reg_index_t;

    localparam int CfgIndexWidth = 4;
    localparam int CfgDataWidth  = 24;

    typedef struct packed {
        logic [11:0] raw_x;
        logic [11:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_led;
    } led_t;

    // One CORDIC cell's working set
    typedef struct packed {
        logic        valid;
        logic signed [22:0] x;
        logic signed [22:0] y;
        logic [15:0] z;
        logic        show;
    } cordic_word_t;

    function automatic logic [15:0] turn_atan(input logic [3:0] i);
        logic [15:0] v;
        begin
            case (i)
                4'd0:  v = 16'd8192;
                4'd1:  v = 16'd4836;
                4'd2:  v = 16'd2555;
                4'd3:  v = 16'd1297;
                4'd4:  v = 16'd651;
                4'd5:  v = 16'd326;
                4'd6:  v = 16'd163;
                4'd7:  v = 16'd81;
                4'd8:  v = 16'd41;
                4'd9:  v = 16'd20;
                4'd10: v = 16'd10;
                4'd11: v = 16'd5;
                4'd12: v = 16'd3;
                4'd13: v = 16'd1;
                4'd14: v = 16'd1;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    // comp * level / 255, floored
    function automatic logic [7:0] scale8(input logic [7:0] comp, input logic [7:0] lvl);
        logic [15:0] p;
        logic [16:0] q;
        begin
            p = comp * lvl;
            q = ({1'b0, p} + 17'd1 + {9'd0, p[15:8]}) >> 8;
            return q[7:0];
        end
    endfunction

endpackage

[rtl/joystick_ring_pointer_render_top.sv]
// Joystick ring pointer renderer. Each accepted sample (raw_x, raw_y) yields one
// frame of LED_COUNT colour transfers, led_index 0 first, last_led on the final
// one. The sample passes a snap stage, a squaring stage, a chain of 13
// square-root cells and 16 CORDIC cells (the width division runs in cells beside
// the first eight CORDIC cells), then one width stage; a frame is then emitted
// one LED per cycle while m_ready is high. Samples keep entering the chain while
// a frame is emitted, so the next sample is already in the chain when the frame
// ends.
module joystick_ring_pointer_render_top import jrpr_pkg::*; #(
    parameter int LED_COUNT = LedCountDefault,
    parameter int ADC_MAX   = AdcMaxDefault
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  sample_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output led_t                     m_data,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CntW = $clog2(LED_COUNT + 1);
    localparam int SqSteps = 13;

    // Configuration registers
    logic [11:0] stick_center_reg;
    logic [10:0] dead_zone_reg;
    logic [6:0]  width_least_reg, width_most_reg;
    logic [23:0] pointer_rgb_reg, backdrop_rgb_reg;
    logic [7:0]  pointer_level_reg, backdrop_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_center_reg   <= 12'd2048;
            dead_zone_reg      <= 11'd100;
            width_least_reg    <= 7'd1;
            width_most_reg     <= 7'd5;
            pointer_rgb_reg    <= 24'hFFFFFF;
            backdrop_rgb_reg   <= 24'd0;
            pointer_level_reg  <= 8'd255;
            backdrop_level_reg <= 8'd32;
        end else if (cfg_we && cfg_index[3] == 1'b0) begin
            unique case (reg_index_t'(cfg_index[2:0]))
                REG_STICK_CENTER:   stick_center_reg   <= cfg_data[11:0];
                REG_DEAD_ZONE:      dead_zone_reg      <= cfg_data[10:0];
                REG_WIDTH_LEAST:    width_least_reg    <= cfg_data[6:0];
                REG_WIDTH_MOST:     width_most_reg     <= cfg_data[6:0];
                REG_POINTER_RGB:    pointer_rgb_reg    <= cfg_data;
                REG_BACKDROP_RGB:   backdrop_rgb_reg   <= cfg_data;
                REG_POINTER_LEVEL:  pointer_level_reg  <= cfg_data[7:0];
                REG_BACKDROP_LEVEL: backdrop_level_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Chain advances unless a result waits at its end while the frame slot is still emitting
    logic frame_busy_reg;
    logic chain_out_valid;
    logic frame_load;
    logic advance;
    logic last_now;
    assign frame_load = chain_out_valid && (!frame_busy_reg ||
                        (m_ready && last_now));
    assign advance = !chain_out_valid || frame_load;
    assign s_ready = advance;

    // Stage 0: snap axes
    logic signed [12:0] dx_c, dy_c, ax, ay;
    logic signed [12:0] dx_reg, dy_reg;
    logic        v0_reg;
    always_comb begin
        dx_c = $signed({1'b0, s_data.raw_x}) - $signed({1'b0, stick_center_reg});
        dy_c = $signed({1'b0, s_data.raw_y}) - $signed({1'b0, stick_center_reg});
        ax = dx_c < 0 ? -dx_c : dx_c;
        ay = dy_c < 0 ? -dy_c : dy_c;
        if (ax < $signed({2'b0, dead_zone_reg})) dx_c = '0;
        if (ay < $signed({2'b0, dead_zone_reg})) dy_c = '0;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_valid;
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
    end

    // Stage 1: square and sum
    logic [24:0] sq_reg;
    logic signed [12:0] dx1_reg, dy1_reg;
    logic v1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg  <= v0_reg;
            sq_reg  <= unsigned'(25'(dx_reg) * 25'(dx_reg)) +
                       unsigned'(25'(dy_reg) * 25'(dy_reg));
            dx1_reg <= dx_reg;
            dy1_reg <= dy_reg;
        end
    end

    // Square-root chain with valid and offset delay line alongside
    logic [24:0] rem_w  [SqSteps+1];
    logic [12:0] root_w [SqSteps+1];
    logic [SqSteps:0] sv_reg;
    logic signed [12:0] sdx_reg [SqSteps+1];
    logic signed [12:0] sdy_reg [SqSteps+1];
    assign rem_w[0]  = sq_reg;
    assign root_w[0] = '0;
    always_comb begin
        sv_reg[0]  = v1_reg;
        sdx_reg[0] = dx1_reg;
        sdy_reg[0] = dy1_reg;
    end

    for (genvar g = 0; g < SqSteps; g++) begin : g_sq
        jrpr_sqrt_cell #(.STEP(g)) u_cell (
            .aclk     (aclk),
            .advance  (advance),
            .rem_in   (rem_w[g]),
            .root_in  (root_w[g]),
            .rem_out  (rem_w[g+1]),
            .root_out (root_w[g+1])
        );
        logic vq_reg;
        logic signed [12:0] qx_reg, qy_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg <= 1'b0;
            end else if (advance) begin
                vq_reg <= sv_reg[g];
                qx_reg <= sdx_reg[g];
                qy_reg <= sdy_reg[g];
            end
        end
        always_comb begin
            sv_reg[g+1]  = vq_reg;
            sdx_reg[g+1] = qx_reg;
            sdy_reg[g+1] = qy_reg;
        end
    end

    // CORDIC entry: pre-rotate left half-plane
    logic [12:0] mag_c;
    cordic_word_t cw [CordicSteps+1];
    assign mag_c = root_w[SqSteps];
    always_comb begin
        cw[0].valid = sv_reg[SqSteps];
        cw[0].x = 23'(sdx_reg[SqSteps]) <<< 8;
        cw[0].y = 23'(sdy_reg[SqSteps]) <<< 8;
        cw[0].z = '0;
        cw[0].show = mag_c > {2'b0, dead_zone_reg};
        if (sdx_reg[SqSteps] < 0) begin
            cw[0].x = -(23'(sdx_reg[SqSteps]) <<< 8);
            cw[0].y = -(23'(sdy_reg[SqSteps]) <<< 8);
            cw[0].z = 16'd32768;
        end
    end

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
        jrpr_cordic_cell #(.STEP(4'(g))) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_word  (cw[g]),
            .out_word (cw[g+1])
        );
    end

    // Width numerator and denominator, formed at CORDIC entry
    logic signed [17:0] limit_c, eff_c, den_c, wd_c;
    logic signed [25:0] num_c;
    logic [23:0] dr_w [CordicSteps+1];
    logic [16:0] dd_w [CordicSteps+1];
    logic [6:0]  dq_w [CordicSteps+1];
    logic        dneg_w [CordicSteps+1];
    logic        dpos_w [CordicSteps+1];
    always_comb begin
        limit_c = 18'(ADC_MAX) - $signed({6'd0, stick_center_reg});
        eff_c   = $signed({5'd0, mag_c}) - $signed({7'd0, dead_zone_reg});
        if (eff_c > limit_c) eff_c = limit_c;
        den_c = limit_c - $signed({7'd0, dead_zone_reg});
        wd_c  = $signed({11'd0, width_most_reg}) - $signed({11'd0, width_least_reg});
        num_c = 26'(eff_c) * 26'(wd_c);
        dneg_w[0] = num_c < 0;
        dr_w[0]   = 24'(dneg_w[0] ? -num_c : num_c);
        dd_w[0]   = 17'(den_c);
        dq_w[0]   = '0;
        dpos_w[0] = den_c > 0;
    end

    // Division cells beside the CORDIC chain: saturate above 127, then one
    // quotient bit per cell, msb first; later cells only hold
    for (genvar g = 0; g < CordicSteps; g++) begin : g_div
        localparam int DivShift = (g == 0) ? 7 : ((g <= 7) ? 7 - g : 0);
        localparam bit DivSat   = (g == 0);
        localparam bit DivStep  = (g >= 1) && (g <= 7);
        logic [23:0] dr_reg, dr_next;
        logic [16:0] dd_reg;
        logic [6:0]  dq_reg, dq_next;
        logic        dneg_reg, dpos_reg;
        logic [24:0] dtry;
        always_comb begin
            dtry    = {1'b0, dd_w[g], 7'd0} >> (7 - DivShift);
            dr_next = dr_w[g];
            dq_next = dq_w[g];
            if ((DivSat || DivStep) && ({1'b0, dr_w[g]} >= dtry)) begin
                if (DivSat) begin
                    dr_next = '0;
                    dq_next = '1;
                end else begin
                    dr_next = dr_w[g] - dtry[23:0];
                    dq_next = dq_w[g] | (7'd1 << DivShift);
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) begin
                dr_reg   <= dr_next;
                dd_reg   <= dd_w[g];
                dq_reg   <= dq_next;
                dneg_reg <= dneg_w[g];
                dpos_reg <= dpos_w[g];
            end
        end
        always_comb begin
            dr_w[g+1]   = dr_reg;
            dd_w[g+1]   = dd_reg;
            dq_w[g+1]   = dq_reg;
            dneg_w[g+1] = dneg_reg;
            dpos_w[g+1] = dpos_reg;
        end
    end

    // Width stage
    logic signed [17:0] q_c, w_c;
    logic [15:0] rot_c;
    logic [IdxW-1:0] centre_reg;
    logic [CntW-1:0] width_reg;
    logic show_reg, v2_reg;
    always_comb begin
        q_c = $signed({11'd0, dq_w[CordicSteps]});
        if (dneg_w[CordicSteps]) q_c = -q_c;
        if (!dpos_w[CordicSteps]) q_c = '0;
        w_c = $signed({11'd0, width_least_reg}) + q_c;
        if (w_c < $signed({11'd0, width_least_reg})) w_c = $signed({11'd0, width_least_reg});
        else if (w_c > $signed({11'd0, width_most_reg})) w_c = $signed({11'd0, width_most_reg});
        if (w_c > LED_COUNT) w_c = 18'(LED_COUNT);
        rot_c = cw[CordicSteps].z + 16'd16384;
    end
    assign chain_out_valid = v2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg     <= cw[CordicSteps].valid;
            width_reg  <= CntW'(w_c);
            show_reg   <= cw[CordicSteps].show;
            centre_reg <= IdxW'((32'(rot_c) * 32'(LED_COUNT)) >> 16);
        end
    end

    // Frame emission, one LED per transfer
    logic [IdxW-1:0] led_reg, centre_f_reg;
    logic [CntW-1:0] width_f_reg;
    logic show_f_reg;
    logic [7:0] dim_level;
    logic [IdxW+1:0] span_sum;
    logic [IdxW:0] offs;
    logic [IdxW-1:0] rel;
    logic [CntW-1:0] half;
    logic lit, full;
    logic [23:0] rgb;
    logic [7:0] lvl;

    assign last_now = (32'(led_reg) == LED_COUNT - 1);
    // Two thirds of the level, floored, by reciprocal multiply
    assign dim_level = 8'((19'(pointer_level_reg) * 19'd1366) >> 11);
    assign m_valid = frame_busy_reg;

    always_comb begin
        half = width_f_reg >> 1;
        // position i of this LED in the span: (led - centre + half) mod LED_COUNT
        span_sum = (IdxW+2)'(led_reg) + (IdxW+2)'(LED_COUNT) - (IdxW+2)'(centre_f_reg) +
                   (IdxW+2)'(half);
        if (span_sum >= (IdxW+2)'(2 * LED_COUNT))
            offs = (IdxW+1)'(span_sum - (IdxW+2)'(2 * LED_COUNT));
        else if (span_sum >= (IdxW+2)'(LED_COUNT))
            offs = (IdxW+1)'(span_sum - (IdxW+2)'(LED_COUNT));
        else
            offs = (IdxW+1)'(span_sum);
        rel  = offs[IdxW-1:0];
        lit  = show_f_reg && ((CntW+1)'(offs) < (CntW+1)'(width_f_reg));
        full = (width_f_reg == 1) || (CntW'(rel) == half) ||
               (!width_f_reg[0] && (CntW'(rel) + 1'b1 == half));
        rgb  = lit ? pointer_rgb_reg : backdrop_rgb_reg;
        lvl  = lit ? (full ? pointer_level_reg : dim_level) : backdrop_level_reg;
        m_data.led_index = 6'(led_reg);
        m_data.red       = scale8(rgb[23:16], lvl);
        m_data.green     = scale8(rgb[15:8], lvl);
        m_data.blue      = scale8(rgb[7:0], lvl);
        m_data.last_led  = last_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_busy_reg <= 1'b0;
            led_reg        <= '0;
        end else begin
            if (frame_load) begin
                frame_busy_reg <= 1'b1;
                led_reg        <= '0;
                centre_f_reg   <= centre_reg;
                width_f_reg    <= width_reg;
                show_f_reg     <= show_reg;
            end else if (m_valid && m_ready) begin
                if (last_now) begin
                    frame_busy_reg <= 1'b0;
                    led_reg        <= '0;
                end else begin
                    led_reg <= led_reg + 1'b1;
                end
            end
        end
    end

    // Frame always starts at LED zero
    a_first_led: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_load |=> (led_reg == '0)) else $error("frame not at LED zero");
    // Counter only moves on a transfer or a new frame
    a_led_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !frame_load) |=> $stable(led_reg))
        else $error("LED counter moved without transfer");
    // Chain never advances over a pending, unloaded result
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_out_valid && !frame_load) |-> !advance)
        else $error("chain advanced over pending result");

endmodule

[rtl/jrpr_cordic_cell.sv]
module jrpr_cordic_cell import jrpr_pkg::*; #(
    parameter logic [3:0] STEP = 4'd0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         advance,
    input  cordic_word_t in_word,
    output cordic_word_t out_word
);

    cordic_word_t word_reg, word_next;
    logic signed [22:0] xs, ys;

    // One vectoring rotation with floor shifts
    always_comb begin
        xs = in_word.x >>> STEP;
        ys = in_word.y >>> STEP;
        word_next = in_word;
        if (in_word.y < 0) begin
            word_next.x = in_word.x - ys;
            word_next.y = in_word.y + xs;
            word_next.z = in_word.z - turn_atan(STEP);
        end else begin
            word_next.x = in_word.x + ys;
            word_next.y = in_word.y - xs;
            word_next.z = in_word.z + turn_atan(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (advance) begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

[rtl/jrpr_sqrt_cell.sv]
module jrpr_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        aclk,
    input  logic        advance,
    input  logic [24:0] rem_in,
    input  logic [12:0] root_in,
    output logic [24:0] rem_out,
    output logic [12:0] root_out
);

    // Restoring square root: one result bit per cell, msb first
    localparam int Bit = 12 - STEP;

    logic [24:0] rem_reg, rem_next;
    logic [12:0] root_reg, root_next;
    logic [25:0] trial;

    always_comb begin
        trial = ({13'd0, root_in} << (Bit + 1)) + (26'd1 << (2 * Bit));
        rem_next  = rem_in;
        root_next = root_in;
        if ({1'b0, rem_in} >= trial) begin
            rem_next  = rem_in - trial[24:0];
            root_next = root_in | (13'd1 << Bit);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

[test/tb_joystick_ring_pointer_render_top.sv]
`timescale 1ns / 100ps

module tb_joystick_ring_pointer_render_top;
    import jrpr_pkg::*;

    localparam int LEDS     = 32;
    localparam int ADC_TOP  = 4095;
    localparam int MAX_CYC  = 400000;

    // Register copy held by the frame predictor
    class frame_scoreboard;
        int unsigned center, dzone, wleast, wmost;
        int unsigned ptr_rgb, bg_rgb, ptr_lvl, bg_lvl;
        led_t pending[$];
        int errors;

        function void set_defaults();
            center = 2048; dzone = 100; wleast = 1; wmost = 5;
            ptr_rgb = 24'hFFFFFF; bg_rgb = 0; ptr_lvl = 255; bg_lvl = 32;
            errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, int unsigned val);
            case (idx)
                REG_STICK_CENTER:   center  = val & 12'hFFF;
                REG_DEAD_ZONE:      dzone   = val & 11'h7FF;
                REG_WIDTH_LEAST:    wleast  = val & 7'h7F;
                REG_WIDTH_MOST:     wmost   = val & 7'h7F;
                REG_POINTER_RGB:    ptr_rgb = val & 24'hFFFFFF;
                REG_BACKDROP_RGB:   bg_rgb  = val & 24'hFFFFFF;
                REG_POINTER_LEVEL:  ptr_lvl = val & 8'hFF;
                REG_BACKDROP_LEVEL: bg_lvl  = val & 8'hFF;
                default: ;
            endcase
        endfunction

        function int snap(int unsigned raw);
            int d;
            d = int'(raw) - int'(center);
            return ((d < 0 ? -d : d) < int'(dzone)) ? 0 : d;
        endfunction

        function int unsigned root_floor(longint unsigned v);
            longint unsigned r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return int'(r);
        endfunction

        function bit [15:0] heading(int dx, int dy);
            int x, y, xs, ys;
            bit [15:0] z;
            bit [15:0] atab [16] = '{16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651,
                16'd326, 16'd163, 16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3,
                16'd1, 16'd1, 16'd0};
            x = dx * 256; y = dy * 256; z = 0;
            if (x < 0) begin
                x = -x; y = -y; z = 16'd32768;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i; ys = y >>> i;
                if (y < 0) begin
                    x = x - ys; y = y + xs; z = z - atab[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atab[i];
                end
            end
            return z;
        endfunction

        function bit [7:0] dim(int unsigned comp, int unsigned lvl);
            return 8'(((comp & 255) * (lvl & 255)) / 255);
        endfunction

        // Render one frame of expected LED transfers
        function void note_sample(sample_t s);
            int unsigned lvl [LEDS];
            bit lit [LEDS];
            int dx, dy, ctr, lim, eff, den, w, half, idx;
            int unsigned mag, rgb, lv;
            bit [15:0] rot;
            led_t e;
            dx = snap(s.raw_x); dy = snap(s.raw_y);
            mag = root_floor(longint'(dx) * dx + longint'(dy) * dy);
            for (int k = 0; k < LEDS; k++) begin
                lit[k] = 0; lvl[k] = 0;
            end
            if (mag > dzone) begin
                rot = heading(dx, dy) + 16'd16384;
                ctr = (int'(rot) * LEDS) >> 16;
                lim = ADC_TOP - int'(center);
                eff = int'(mag) - int'(dzone);
                den = lim - int'(dzone);
                if (eff > lim) eff = lim;
                if (den > 0) w = int'(wleast) + (eff * (int'(wmost) - int'(wleast))) / den;
                else w = wleast;
                if (w < int'(wleast)) w = wleast;
                else if (w > int'(wmost)) w = wmost;
                if (w > LEDS) w = LEDS;
                half = w / 2;
                for (int i = 0; i < w; i++) begin
                    idx = (ctr + i - half) % LEDS;
                    if (idx < 0) idx += LEDS;
                    lit[idx] = 1;
                    if (w == 1 || i == half || (w % 2 == 0 && i == half - 1))
                        lvl[idx] = ptr_lvl;
                    else
                        lvl[idx] = ptr_lvl * 2 / 3;
                end
            end
            for (int k = 0; k < LEDS; k++) begin
                rgb = lit[k] ? ptr_rgb : bg_rgb;
                lv = lit[k] ? lvl[k] : bg_lvl;
                e.led_index = 6'(k);
                e.red = dim(rgb >> 16, lv);
                e.green = dim(rgb >> 8, lv);
                e.blue = dim(rgb, lv);
                e.last_led = (k == LEDS - 1);
                pending.push_back(e);
            end
        endfunction

        function void check_led(led_t got);
            led_t e;
            if (pending.size() == 0) begin
                $error("unexpected LED transfer %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.led_index !== e.led_index) begin
                $error("led_index: expected %0d, got %0d", e.led_index, got.led_index);
                errors++;
            end
            if (got.red !== e.red) begin
                $error("red: expected %0d, got %0d", e.red, got.red);
                errors++;
            end
            if (got.green !== e.green) begin
                $error("green: expected %0d, got %0d", e.green, got.green);
                errors++;
            end
            if (got.blue !== e.blue) begin
                $error("blue: expected %0d, got %0d", e.blue, got.blue);
                errors++;
            end
            if (got.last_led !== e.last_led) begin
                $error("last_led: expected %0d, got %0d", e.last_led, got.last_led);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, m_ready = 0, cfg_we = 0;
    sample_t s_data = '0;
    led_t m_data;
    logic s_ready, m_valid;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    int cycles = 0;
    frame_scoreboard board;

    joystick_ring_pointer_render_top i_dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("** joystick_ring_pointer_render_top: FAILED **");
            $finish;
        end
    end

    // Check every LED transfer at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_led(m_data);
    end

    function int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Drive result-side stalls; some stretches with none
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (cycles % 3000 < 600) m_ready <= 1;
            else begin
                g = gap_len();
                m_ready <= (g == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    // Present one sample at the falling edge and hold it until the transfer
    task automatic send_sample(logic [11:0] x, logic [11:0] y, bit do_gap);
        int g;
        sample_t s;
        g = do_gap ? gap_len() : 0;
        s.raw_x = x; s.raw_y = y;
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_sample(s);
    endtask

    // Drop valid after the last transfer of a burst
    task automatic stop_input();
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic drain();
        stop_input();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, int unsigned val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= CfgIndexWidth'(idx);
        cfg_data <= CfgDataWidth'(val);
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_config();
        write_reg(REG_STICK_CENTER, $urandom_range(0, 9) == 0 ? $urandom_range(3900, 4095)
                                                              : $urandom_range(1500, 2600));
        write_reg(REG_DEAD_ZONE, $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, 300));
        write_reg(REG_WIDTH_LEAST, $urandom_range(0, 64));
        write_reg(REG_WIDTH_MOST, $urandom_range(0, 64));
        write_reg(REG_POINTER_RGB, $urandom_range(0, 24'hFFFFFF));
        write_reg(REG_BACKDROP_RGB, $urandom_range(0, 24'hFFFFFF));
        write_reg(REG_POINTER_LEVEL, $urandom_range(0, 255));
        write_reg(REG_BACKDROP_LEVEL, $urandom_range(0, 255));
    endtask

    initial begin
        board = new();
        board.set_defaults();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: center, rails, corners, deadzone edges, each direction
        send_sample(12'd2048, 12'd2048, 0);
        send_sample(12'd2148, 12'd2048, 0);
        send_sample(12'd2149, 12'd2048, 0);
        send_sample(12'd4095, 12'd2048, 0);
        send_sample(12'd0, 12'd2048, 0);
        send_sample(12'd2048, 12'd4095, 0);
        send_sample(12'd2048, 12'd0, 0);
        send_sample(12'd4095, 12'd4095, 0);
        send_sample(12'd0, 12'd0, 0);
        send_sample(12'd0, 12'd4095, 0);
        send_sample(12'd4095, 12'd0, 0);
        send_sample(12'd2120, 12'd2120, 0);
        drain();

        // Wide pointer saturating to LED count, least above most
        write_reg(REG_WIDTH_LEAST, 64);
        write_reg(REG_WIDTH_MOST, 40);
        write_reg(REG_POINTER_RGB, 24'h123456);
        write_reg(REG_BACKDROP_RGB, 24'hFFFFFF);
        write_reg(REG_BACKDROP_LEVEL, 255);
        send_sample(12'd3000, 12'd1000, 0);
        drain();
        // Zero widths, zero deadzone, even width
        write_reg(REG_WIDTH_LEAST, 0);
        write_reg(REG_WIDTH_MOST, 0);
        write_reg(REG_DEAD_ZONE, 0);
        send_sample(12'd2049, 12'd2048, 0);
        send_sample(12'd2047, 12'd2047, 0);
        drain();
        write_reg(REG_WIDTH_LEAST, 4);
        write_reg(REG_WIDTH_MOST, 4);
        write_reg(REG_POINTER_LEVEL, 0);
        write_reg(REG_DEAD_ZONE, 2047);
        send_sample(12'd0, 12'd0, 0);
        drain();
        // Center at the top: zero limit and negative denominator
        write_reg(REG_STICK_CENTER, 4095);
        write_reg(REG_DEAD_ZONE, 10);
        write_reg(REG_POINTER_LEVEL, 200);
        send_sample(12'd0, 12'd4095, 0);
        send_sample(12'd100, 12'd3000, 0);
        drain();
        write_reg(REG_STICK_CENTER, 0);
        send_sample(12'd4095, 12'd4095, 0);
        send_sample(12'd5, 12'd2000, 0);
        drain();

        // Random phases with a new setting each
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            for (int n = 0; n < 14; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1);
                else
                    send_sample(12'(board.center + $urandom_range(0, 1200) - 600),
                                12'(board.center + $urandom_range(0, 1200) - 600), 1);
                // hold off until every frame is out
                if (n == 8 && ph == 3) begin
                    stop_input();
                    while (board.pending.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("** joystick_ring_pointer_render_top: PASSED **");
        else
            $display("** joystick_ring_pointer_render_top: FAILED **");
        $finish;
    end
endmodule
